// ===== src/mpq_pkg.sv =====
package mpq_pkg;

    localparam int DEF_QUEUE_DEPTH = 32;
    localparam int KEY_W           = 32;
    localparam int TAG_W           = 8;
    localparam int OCC_W           = 6;

    // kind field codes
    localparam logic KIND_INSERT  = 1'b0;
    localparam logic KIND_EXTRACT = 1'b1;

    typedef enum logic [1:0] {
        ST_OK    = 2'd0,
        ST_EMPTY = 2'd1,
        ST_FULL  = 2'd2
    } t_status;

    typedef struct packed {
        logic [KEY_W-1:0] prio;
        logic [KEY_W-1:0] arrival;
        logic [TAG_W-1:0] tag;
    } t_entry;

    // broadcast to every cell each cycle
    typedef struct packed {
        logic   ins;
        logic   ext;
        t_entry new_entry;
    } t_cell_ctl;

    // what a cell shows its neighbors
    typedef struct packed {
        logic   valid;
        logic   beat;   // incoming entry goes ahead of this cell's entry
        t_entry entry;
    } t_cell_out;

endpackage

// ===== src/mpq_if.sv =====
interface mpq_in_if;
    logic        valid;
    logic        ready;
    logic        kind;
    logic [31:0] priority_key;
    logic [31:0] arrival_key;
    logic [7:0]  tag;

    modport source (output valid, kind, priority_key, arrival_key, tag, input ready);
    modport sink   (input valid, kind, priority_key, arrival_key, tag, output ready);
endinterface

interface mpq_out_if;
    logic        valid;
    logic        ready;
    logic [1:0]  status;
    logic [7:0]  out_tag;
    logic [31:0] out_priority;
    logic [31:0] out_arrival;
    logic [5:0]  occupancy;

    modport source (output valid, status, out_tag, out_priority, out_arrival, occupancy,
                    input ready);
    modport sink   (input valid, status, out_tag, out_priority, out_arrival, occupancy,
                    output ready);
endinterface

// ===== src/mpq_cell.sv =====
module mpq_cell
    import mpq_pkg::*;
(
    input  logic      i_clk,
    input  logic      i_rst_n,
    input  t_cell_ctl i_ctl,
    input  t_cell_out i_left,   // better neighbor
    input  t_cell_out i_right,  // worse neighbor
    output t_cell_out o_cell
);

    logic   r_valid;
    t_entry r_entry;
    logic   n_valid;
    t_entry n_entry;
    logic   w_beat;

    // invalid slot is always beaten
    assign w_beat = !r_valid
        || (i_ctl.new_entry.prio < r_entry.prio)
        || ((i_ctl.new_entry.prio == r_entry.prio)
            && (i_ctl.new_entry.arrival < r_entry.arrival));

    always_comb begin
        n_valid = r_valid;
        n_entry = r_entry;
        if (i_ctl.ins && w_beat) begin
            if (i_left.beat) begin
                n_valid = i_left.valid;
                n_entry = i_left.entry;
            end else begin
                n_valid = 1'b1;
                n_entry = i_ctl.new_entry;
            end
        end else if (i_ctl.ext) begin
            n_valid = i_right.valid;
            n_entry = i_right.entry;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else begin
            r_valid <= n_valid;
        end
        r_entry <= n_entry;
    end

    assign o_cell.valid = r_valid;
    assign o_cell.beat  = w_beat;
    assign o_cell.entry = r_entry;

endmodule

// ===== src/min_priority_queue.sv =====
// min_priority_queue: bounded min-priority queue built as a sorted row of cells.
//
// Input channel i_in: kind 0 inserts (priority_key, arrival_key, tag), kind 1
// extracts the best entry (lowest priority, then lowest arrival, then oldest
// insert). Output channel o_out: one result item per input item with status
// (ok, empty on extract, full on insert - entry dropped), the extracted entry
// (zero unless an extract succeeds) and occupancy after the item.
//
// Every cycle the item is broadcast to all QUEUE_DEPTH cells; each cell
// compares it with its own entry and either keeps, takes the new entry, or
// takes a neighbor's entry. All cells update together, whatever the depth.
// The result is registered and appears in the cycle after the item is accepted.
// Throughput: one item per cycle while the output side takes results.
// The output register is the only stage between sides: i_in.ready is high
// when the output register is empty or being taken this cycle.
// When the receiver stalls, the result is held and input stops until it is
// taken. Reset (synchronous, active low) empties the queue and the output
// register; entry payloads are not cleared, only cell valid bits.
module min_priority_queue
    import mpq_pkg::*;
#(
    parameter int QUEUE_DEPTH = DEF_QUEUE_DEPTH
) (
    input  logic i_clk,
    input  logic i_rst_n,
    mpq_in_if.sink    i_in,
    mpq_out_if.source o_out
);

    localparam int CNT_W = $clog2(QUEUE_DEPTH + 1);

    t_cell_ctl  w_ctl;
    t_cell_out  w_cell [QUEUE_DEPTH];
    logic [QUEUE_DEPTH-1:0] w_valid_vec;
    logic [QUEUE_DEPTH-1:0] w_therm;

    logic             w_acc;
    logic             w_full;
    logic             w_empty;
    logic             w_ins;
    logic             w_ext;

    logic [CNT_W-1:0] r_count;
    logic [CNT_W-1:0] n_count;

    logic             r_out_valid;
    t_status          r_status;
    logic [TAG_W-1:0] r_tag;
    logic [KEY_W-1:0] r_prio;
    logic [KEY_W-1:0] r_arrival;
    logic [OCC_W-1:0] r_occ;

    t_status          n_status;
    t_entry           n_res;

    assign i_in.ready = !r_out_valid || o_out.ready;
    assign w_acc      = i_in.valid && i_in.ready;
    assign w_full     = (r_count == CNT_W'(QUEUE_DEPTH));
    assign w_empty    = (r_count == '0);
    assign w_ins      = w_acc && (i_in.kind == KIND_INSERT) && !w_full;
    assign w_ext      = w_acc && (i_in.kind == KIND_EXTRACT) && !w_empty;

    assign w_ctl.ins               = w_ins;
    assign w_ctl.ext               = w_ext;
    assign w_ctl.new_entry.prio    = i_in.priority_key;
    assign w_ctl.new_entry.arrival = i_in.arrival_key;
    assign w_ctl.new_entry.tag     = i_in.tag;

    // cell row: index 0 holds the best entry
    genvar g;
    generate
        for (g = 0; g < QUEUE_DEPTH; g++) begin : g_cell
            t_cell_out w_left;
            t_cell_out w_right;
            if (g == 0) begin : g_head
                assign w_left = '0;   // nothing ahead: never shifts in from left
            end else begin : g_mid_l
                assign w_left = w_cell[g-1];
            end
            if (g == QUEUE_DEPTH - 1) begin : g_tail
                assign w_right = '0;
            end else begin : g_mid_r
                assign w_right = w_cell[g+1];
            end
            mpq_cell u_cell (
                .i_clk   (i_clk),
                .i_rst_n (i_rst_n),
                .i_ctl   (w_ctl),
                .i_left  (w_left),
                .i_right (w_right),
                .o_cell  (w_cell[g])
            );
            assign w_valid_vec[g] = w_cell[g].valid;
            assign w_therm[g]     = (CNT_W'(g) < r_count);
        end
    endgenerate

    always_comb begin
        n_count = r_count;
        if (w_ins) begin
            n_count = r_count + CNT_W'(1);
        end else if (w_ext) begin
            n_count = r_count - CNT_W'(1);
        end
    end

    // result of the accepted item
    always_comb begin
        n_status = ST_OK;
        n_res    = '0;
        if (i_in.kind == KIND_INSERT) begin
            if (w_full) begin
                n_status = ST_FULL;
            end
        end else if (w_empty) begin
            n_status = ST_EMPTY;
        end else begin
            n_res = w_cell[0].entry;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_count     <= '0;
            r_out_valid <= 1'b0;
        end else begin
            r_count <= n_count;
            if (w_acc) begin
                r_out_valid <= 1'b1;
            end else if (o_out.ready) begin
                r_out_valid <= 1'b0;
            end
        end
        if (w_acc) begin
            r_status  <= n_status;
            r_tag     <= n_res.tag;
            r_prio    <= n_res.prio;
            r_arrival <= n_res.arrival;
            r_occ     <= OCC_W'(n_count);
        end
    end

    assign o_out.valid        = r_out_valid;
    assign o_out.status       = r_status;
    assign o_out.out_tag      = r_tag;
    assign o_out.out_priority = r_prio;
    assign o_out.out_arrival  = r_arrival;
    assign o_out.occupancy    = r_occ;

    // count stays within the row
    a_count_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_count <= CNT_W'(QUEUE_DEPTH))
        else $error("entry count beyond queue depth");

    // valid cells are exactly the first r_count cells
    a_valid_packed: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_valid_vec == w_therm)
        else $error("cell valid bits disagree with count");

    // head of queue never has a higher priority key than the cell behind it
    a_head_sorted: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (QUEUE_DEPTH > 1 && w_cell[0].valid && w_valid_vec[QUEUE_DEPTH > 1 ? 1 : 0])
        |-> (w_cell[0].entry.prio <= w_cell[QUEUE_DEPTH > 1 ? 1 : 0].entry.prio))
        else $error("head entry out of order");

    // successful extract shrinks the queue by one
    a_extract_count: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_ext |=> (r_count == $past(r_count) - CNT_W'(1)) && (r_status == ST_OK))
        else $error("extract did not remove one entry");

    // dropped insert leaves the count alone and reports full
    a_full_drop: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (w_acc && (i_in.kind == KIND_INSERT) && w_full)
        |=> $stable(r_count) && (r_status == ST_FULL))
        else $error("insert on full queue mishandled");

endmodule

// ===== tb/sv/tb_min_priority_queue.sv =====
module tb_min_priority_queue;
    import mpq_pkg::*;

    localparam int QUEUE_DEPTH    = 32;
    localparam int RANDOM_ITEMS   = 1300;
    localparam int LONG_HOLD      = 120;   // receiver hold-off, cycles
    localparam int WATCHDOG_LIMIT = 2000;  // cycles without any handshake
    localparam int TAIL_CYCLES    = 4;     // result appears in the cycle after its item

    typedef struct {
        logic   kind;
        t_entry e;
    } t_request;

    typedef struct {
        t_status     status;
        logic [7:0]  tag;
        logic [31:0] prio;
        logic [31:0] arrival;
        logic [5:0]  occ;
    } t_reply;

    typedef struct {
        t_request req;
        bit       typed;   // want holds a typed-in reply
        t_reply   want;
    } t_row;

    // random part: share of inserts per phase
    typedef enum int {
        MIX_FILL,
        MIX_DRAIN,
        MIX_EVEN
    } t_mix;

    logic i_clk;
    logic i_rst_n;

    mpq_in_if  req_ch ();
    mpq_out_if rsp_ch ();

    min_priority_queue #(
        .QUEUE_DEPTH(QUEUE_DEPTH)
    ) DUT (
        .i_clk  (i_clk),
        .i_rst_n(i_rst_n),
        .i_in   (req_ch),
        .o_out  (rsp_ch)
    );

    initial i_clk = 1'b0;
    always #5 i_clk = ~i_clk;

    // shadow copy of the queue, sorted best first
    t_entry held[QUEUE_DEPTH];
    int     held_count;

    t_reply replies_due[$];
    int     fault_count;
    int     idle_cycles;
    bit     long_hold_req;

    // apply one item to the shadow queue, return the reply it should produce
    function automatic t_reply queue_apply(t_request r);
        t_reply rep;
        int     pos;
        int     i;
        rep.status  = ST_OK;
        rep.tag     = '0;
        rep.prio    = '0;
        rep.arrival = '0;
        if (r.kind == KIND_INSERT) begin
            if (held_count >= QUEUE_DEPTH) begin
                rep.status = ST_FULL;
            end else begin
                // new entry goes behind everything not worse than it
                pos = 0;
                while (pos < held_count &&
                       !((r.e.prio < held[pos].prio) ||
                         (r.e.prio == held[pos].prio && r.e.arrival < held[pos].arrival)))
                    pos++;
                for (i = held_count; i > pos; i--)
                    held[i] = held[i-1];
                held[pos] = r.e;
                held_count++;
            end
        end else if (held_count == 0) begin
            rep.status = ST_EMPTY;
        end else begin
            rep.tag     = held[0].tag;
            rep.prio    = held[0].prio;
            rep.arrival = held[0].arrival;
            for (i = 1; i < held_count; i++)
                held[i-1] = held[i];
            held_count--;
        end
        rep.occ = 6'(held_count);
        return rep;
    endfunction

    function automatic t_row stim_row(logic kind, logic [31:0] p, logic [31:0] a,
                                      logic [7:0] t, bit typed, t_status st, int occ);
        t_row r;
        r.req.kind       = kind;
        r.req.e.prio     = p;
        r.req.e.arrival  = a;
        r.req.e.tag      = t;
        r.typed          = typed;
        r.want.status    = st;
        r.want.tag       = '0;
        r.want.prio      = '0;
        r.want.arrival   = '0;
        r.want.occ       = 6'(occ);
        return r;
    endfunction

    // keys biased toward ties and extremes
    function automatic logic [31:0] pick_key();
        case ($urandom_range(0, 3))
            0:       return $urandom;
            1:       return 32'($urandom_range(0, 3));
            2:       return ($urandom_range(0, 1) != 0) ? 32'hFFFF_FFFF : 32'h0;
            default: return {16'($urandom_range(0, 3)), 16'h0};
        endcase
    endfunction

    // offer one item from the next falling edge until it is taken
    task automatic offer_request(t_request r, bit typed, t_reply want);
        t_reply rep;
        @(negedge i_clk);
        req_ch.valid        <= 1'b1;
        req_ch.kind         <= r.kind;
        req_ch.priority_key <= r.e.prio;
        req_ch.arrival_key  <= r.e.arrival;
        req_ch.tag          <= r.e.tag;
        do @(posedge i_clk); while (!req_ch.ready);
        rep = queue_apply(r);
        replies_due.push_back(typed ? want : rep);
    endtask

    // sender idle, payload toggles as noise
    task automatic sender_gap(int n);
        repeat (n) begin
            @(negedge i_clk);
            req_ch.valid        <= 1'b0;
            req_ch.kind         <= 1'($urandom);
            req_ch.priority_key <= $urandom;
            req_ch.arrival_key  <= $urandom;
            req_ch.tag          <= 8'($urandom);
        end
    endtask

    task automatic wait_all_replies();
        sender_gap(1);
        while (replies_due.size() != 0)
            @(posedge i_clk);
    endtask

    // receiver: rotating stall pattern, plus a long hold-off on request
    initial begin : receiver
        int stall_left;
        int rx_phase;
        stall_left   = 0;
        rx_phase     = 0;
        rsp_ch.ready = 1'b0;
        @(posedge i_rst_n);
        forever begin
            @(negedge i_clk);
            rx_phase++;
            if (stall_left > 0) begin
                stall_left--;
                rsp_ch.ready <= 1'b0;
            end else if (long_hold_req) begin
                long_hold_req = 1'b0;
                stall_left    = LONG_HOLD - 1;
                rsp_ch.ready <= 1'b0;
            end else begin
                case ((rx_phase / 50) % 4)
                    0:       rsp_ch.ready <= 1'b1;
                    1:       rsp_ch.ready <= ($urandom_range(0, 99) < 60);
                    2:       rsp_ch.ready <= (rx_phase % 3 == 0);
                    default: rsp_ch.ready <= (rx_phase % 7 != 6);
                endcase
            end
        end
    end

    // result checker, oldest expectation first
    always @(posedge i_clk) begin
        t_reply want;
        if (i_rst_n && rsp_ch.valid && rsp_ch.ready) begin
            if (replies_due.size() == 0) begin
                fault_count++;
                $display("%0t: unexpected result status=%0d tag=%h prio=%h arr=%h occ=%0d",
                         $time, rsp_ch.status, rsp_ch.out_tag, rsp_ch.out_priority,
                         rsp_ch.out_arrival, rsp_ch.occupancy);
            end else begin
                want = replies_due.pop_front();
                if (rsp_ch.status !== want.status) begin
                    fault_count++;
                    $display("%0t: status expected %0d actual %0d",
                             $time, want.status, rsp_ch.status);
                end
                if (rsp_ch.out_tag !== want.tag) begin
                    fault_count++;
                    $display("%0t: out_tag expected %h actual %h",
                             $time, want.tag, rsp_ch.out_tag);
                end
                if (rsp_ch.out_priority !== want.prio) begin
                    fault_count++;
                    $display("%0t: out_priority expected %h actual %h",
                             $time, want.prio, rsp_ch.out_priority);
                end
                if (rsp_ch.out_arrival !== want.arrival) begin
                    fault_count++;
                    $display("%0t: out_arrival expected %h actual %h",
                             $time, want.arrival, rsp_ch.out_arrival);
                end
                if (rsp_ch.occupancy !== want.occ) begin
                    fault_count++;
                    $display("%0t: occupancy expected %0d actual %0d",
                             $time, want.occ, rsp_ch.occupancy);
                end
            end
        end
    end

    // watchdog: no handshake on either side for too long
    always @(posedge i_clk) begin
        if (!i_rst_n || (req_ch.valid && req_ch.ready) || (rsp_ch.valid && rsp_ch.ready)) begin
            idle_cycles = 0;
        end else begin
            idle_cycles++;
            if (idle_cycles >= WATCHDOG_LIMIT) begin
                $display("FAILURE");
                $finish;
            end
        end
    end

    initial begin : stimulus
        t_row     directed[$];
        t_request r;
        t_reply   none;
        t_mix     mix;
        int       sent;
        int       phase_left;
        int       phase_no;
        int       burst_left;
        int       insert_pct;

        held_count          = 0;
        fault_count         = 0;
        idle_cycles         = 0;
        long_hold_req       = 1'b0;
        none                = '{ST_OK, '0, '0, '0, '0};
        i_rst_n             = 1'b0;
        req_ch.valid        = 1'b0;
        req_ch.kind         = KIND_INSERT;
        req_ch.priority_key = '0;
        req_ch.arrival_key  = '0;
        req_ch.tag          = '0;

        repeat (6) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;

        // directed: empty extract, extremes, priority and arrival ties, drain to empty
        directed.push_back(stim_row(KIND_EXTRACT, 0, 0, 0, 1, ST_EMPTY, 0));
        directed.push_back(stim_row(KIND_INSERT, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 8'hFF,
                                    1, ST_OK, 1));
        directed.push_back(stim_row(KIND_INSERT, 0, 0, 8'h00, 1, ST_OK, 2));
        directed.push_back(stim_row(KIND_INSERT, 32'h0001_0000, 5, 8'h11, 0, ST_OK, 0));
        // same priority, earlier arrival goes first
        directed.push_back(stim_row(KIND_INSERT, 32'h0001_0000, 3, 8'h22, 0, ST_OK, 0));
        // full ties keep insertion order
        directed.push_back(stim_row(KIND_INSERT, 32'h0001_0000, 3, 8'h33, 0, ST_OK, 0));
        directed.push_back(stim_row(KIND_INSERT, 32'h0001_0000, 3, 8'h44, 0, ST_OK, 0));
        directed.push_back(stim_row(KIND_INSERT, 32'hFFFF_FFFF, 0, 8'hAA, 0, ST_OK, 0));
        directed.push_back(stim_row(KIND_INSERT, 32'hAAAA_AAAA, 32'h5555_5555, 8'h5A,
                                    0, ST_OK, 0));
        directed.push_back(stim_row(KIND_INSERT, 32'h5555_5555, 32'hAAAA_AAAA, 8'hA5,
                                    0, ST_OK, 0));
        repeat (9)
            directed.push_back(stim_row(KIND_EXTRACT, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 8'hFF,
                                        0, ST_OK, 0));
        directed.push_back(stim_row(KIND_EXTRACT, 0, 0, 0, 1, ST_EMPTY, 0));

        foreach (directed[k]) begin
            offer_request(directed[k].req, directed[k].typed, directed[k].want);
            sender_gap($urandom_range(0, 2));
        end
        wait_all_replies();

        // random: fill, drain and even phases with bursty sender
        sent       = 0;
        phase_no   = 0;
        phase_left = 0;
        burst_left = 0;
        insert_pct = 50;
        while (sent < RANDOM_ITEMS) begin
            if (phase_left == 0) begin
                phase_no++;
                if (phase_no == 5)
                    long_hold_req = 1'b1;   // sender keeps offering through it
                if (phase_no % 7 == 3)
                    wait_all_replies();
                mix = t_mix'($urandom_range(0, 2));
                case (mix)
                    MIX_FILL:  insert_pct = 85;
                    MIX_DRAIN: insert_pct = 15;
                    default:   insert_pct = 50;
                endcase
                phase_left = $urandom_range(20, 80);
            end
            if (burst_left == 0) begin
                sender_gap($urandom_range(0, 5));
                burst_left = $urandom_range(1, 24);
            end
            r.kind      = ($urandom_range(0, 99) < insert_pct) ? KIND_INSERT : KIND_EXTRACT;
            r.e.prio    = pick_key();
            r.e.arrival = pick_key();
            r.e.tag     = 8'($urandom);
            offer_request(r, 1'b0, none);
            sent++;
            phase_left--;
            burst_left--;
        end

        wait_all_replies();
        repeat (TAIL_CYCLES) @(posedge i_clk);

        if (fault_count == 0 && replies_due.size() == 0)
            $display("SUCCESS");
        else
            $display("FAILURE");
        $finish;
    end

endmodule
